// ===== hdl/stack_bytecode_machine_unit_assert.svh =====
// assertion macros used by the checker file
`ifndef STACK_BYTECODE_MACHINE_UNIT_ASSERT_SVH
`define STACK_BYTECODE_MACHINE_UNIT_ASSERT_SVH

// antecedent holds in this cycle, consequent in the same cycle
`define SBM_ASSERT_NOW(lbl, ck, rs, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |-> (cons)) else $error(msg);

// antecedent holds in this cycle, consequent in the next one
`define SBM_ASSERT_NEXT(lbl, ck, rs, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |=> (cons)) else $error(msg);

`endif

// ===== hdl/sbm_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package sbm_pkg;

  localparam int MEM_BYTES   = 4096;
  localparam int STACK_WORDS = 64;
  localparam int AW          = $clog2(MEM_BYTES);
  localparam int SW          = $clog2(STACK_WORDS);
  localparam int DW          = $clog2(STACK_WORDS + 1);
  localparam int PW          = 13;

  localparam int IN_W  = 24;
  localparam int OUT_W = 72;

  localparam logic [1:0] MODE_WRITE   = 2'd0;
  localparam logic [1:0] MODE_READ    = 2'd1;
  localparam logic [1:0] MODE_RESTART = 2'd2;
  localparam logic [1:0] MODE_STEP    = 2'd3;

  localparam logic [1:0] RUN_OK     = 2'd0;
  localparam logic [1:0] RUN_HALTED = 2'd1;
  localparam logic [1:0] RUN_ERROR  = 2'd2;

  localparam logic [2:0] ERR_NONE   = 3'd0;
  localparam logic [2:0] ERR_BOUNDS = 3'd1;
  localparam logic [2:0] ERR_UNDER  = 3'd2;
  localparam logic [2:0] ERR_OVER   = 3'd3;
  localparam logic [2:0] ERR_DIVZ   = 3'd4;

  localparam logic [7:0] OP_HALT    = 8'd0;
  localparam logic [7:0] OP_PUSH0   = 8'd1;
  localparam logic [7:0] OP_PUSH8   = 8'd2;
  localparam logic [7:0] OP_PUSH16  = 8'd3;
  localparam logic [7:0] OP_PUSH32  = 8'd4;
  localparam logic [7:0] OP_DROP    = 8'd5;
  localparam logic [7:0] OP_DUP     = 8'd6;
  localparam logic [7:0] OP_ADD     = 8'd7;
  localparam logic [7:0] OP_SUB     = 8'd8;
  localparam logic [7:0] OP_MUL     = 8'd9;
  localparam logic [7:0] OP_DIV     = 8'd10;
  localparam logic [7:0] OP_MOD     = 8'd11;
  localparam logic [7:0] OP_EQ      = 8'd12;
  localparam logic [7:0] OP_NEQ     = 8'd13;
  localparam logic [7:0] OP_LOAD8   = 8'd14;
  localparam logic [7:0] OP_LOAD16  = 8'd15;
  localparam logic [7:0] OP_LOAD32  = 8'd16;
  localparam logic [7:0] OP_STORE8  = 8'd17;
  localparam logic [7:0] OP_STORE16 = 8'd18;
  localparam logic [7:0] OP_STORE32 = 8'd19;

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_RDWAIT, S_FETCH, S_IMM, S_BREAD, S_DIV, S_DIVEND,
    S_MEMWR, S_TOPRD, S_PUSH, S_DONE
  } state_t;

  // access size in bytes minus one for immediates, loads and stores
  function automatic logic [1:0] size_m1(input logic [7:0] op);
    case (op)
      OP_PUSH8, OP_LOAD8, OP_STORE8:    size_m1 = 2'd0;
      OP_PUSH16, OP_LOAD16, OP_STORE16: size_m1 = 2'd1;
      default:                          size_m1 = 2'd3;
    endcase
  endfunction

endpackage
`default_nettype wire

// ===== hdl/sbm_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none
module sbm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// ===== hdl/stack_bytecode_machine_unit.sv =====
// stack_bytecode_machine_unit: 32-bit stack machine with a 4096-byte memory
// and a 64-word stack.
// input channel s_*: one beat carries mode, address and write_data. mode
// writes a memory byte, reads one, restarts pc and stack, or executes one
// instruction at pc. every input beat gives exactly one output beat on m_*,
// showing the read byte, run state, error code, pc, top of stack and depth.
// the time a step takes is set by the single byte port of the memory (one byte
// a cycle for immediates, loads and stores) and by the one-bit-a-cycle divider.
// the block works on one beat at a time; s_tready is high when it is idle.
// a finished result waits in the output register while the next input beat
// is taken; if m_tready stays low the machine holds in its last stage.
// after reset the memory is swept to zero, one byte a cycle, over all 4096
// bytes; s_tready stays low until the sweep is done.
`timescale 1ns / 1ps
`default_nettype none
module stack_bytecode_machine_unit (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      s_tvalid,
  output logic                           s_tready,
  // mode[1:0], address[13:2], write_data[21:14], zero pad
  input  wire logic [sbm_pkg::IN_W-1:0]  s_tdata,
  output logic                           m_tvalid,
  input  wire logic                      m_tready,
  // read_data[7:0], run_state[9:8], error_code[12:10], program_counter[25:13],
  // top_value[57:26], stack_depth[64:58], zero pad
  output logic      [sbm_pkg::OUT_W-1:0] m_tdata
);
  import sbm_pkg::*;

  state_t state, state_next;
  logic [PW-1:0] pc, pc_next, p, p_next, ptr, ptr_next;
  logic [DW-1:0] depth, depth_next, d, d_next;
  logic [1:0] run, run_next, cnt, cnt_next, nb, nb_next;
  logic [2:0] fault, fault_next;
  logic [31:0] top, top_next, acc, acc_next, b, b_next;
  logic [31:0] div_q, div_q_next, div_r, div_r_next;
  logic [4:0] div_cnt, div_cnt_next;
  logic neg_q, neg_q_next, neg_r, neg_r_next;
  logic [7:0] op, op_next, rd_q, rd_next;
  logic [AW:0] clr, clr_next;
  logic m_tvalid_next;
  logic [OUT_W-1:0] m_tdata_next;

  logic mem_we;
  logic [AW-1:0] mem_waddr, mem_raddr;
  logic [7:0] mem_wdata, mem_rdata;
  logic stk_we;
  logic [SW-1:0] stk_waddr, stk_raddr;
  logic [31:0] stk_wdata, stk_rdata;

  logic [1:0] in_mode;
  logic [11:0] in_addr;
  logic [7:0] in_wdata;
  logic [1:0] n_fetch;
  logic fits_p, fits_top;
  logic [31:0] prod, sum, diff;
  logic [32:0] trial;

  assign in_mode  = s_tdata[1:0];
  assign in_addr  = s_tdata[13:2];
  assign in_wdata = s_tdata[21:14];

  sbm_ram #(.WIDTH(8), .DEPTH(MEM_BYTES)) u_mem (
    .clk, .we(mem_we), .waddr(mem_waddr), .wdata(mem_wdata),
    .raddr(mem_raddr), .rdata(mem_rdata)
  );

  sbm_ram #(.WIDTH(32), .DEPTH(STACK_WORDS)) u_stack (
    .clk, .we(stk_we), .waddr(stk_waddr), .wdata(stk_wdata),
    .raddr(stk_raddr), .rdata(stk_rdata)
  );

  assign n_fetch  = size_m1(mem_rdata);
  // access of n bytes at a is legal when a + n <= MEM_BYTES
  assign fits_p   = ({1'b0, p} + (PW+1)'(n_fetch) + (PW+1)'(1)) <= (PW+1)'(MEM_BYTES);
  assign fits_top = ({1'b0, top} + 33'(size_m1(state == S_FETCH ? mem_rdata : op)) + 33'd1)
                    <= 33'(MEM_BYTES);
  assign prod  = top * stk_rdata;
  assign sum   = top + stk_rdata;
  assign diff  = top - stk_rdata;
  assign trial = {div_r, div_q[31]} - {1'b0, b};

  assign s_tready = (state == S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_CLEAR;
      clr      <= '0;
      pc       <= '0;
      depth    <= '0;
      run      <= RUN_OK;
      fault    <= ERR_NONE;
      top      <= '0;
      m_tvalid <= 1'b0;
    end else begin
      state    <= state_next;
      clr      <= clr_next;
      pc       <= pc_next;
      depth    <= depth_next;
      run      <= run_next;
      fault    <= fault_next;
      top      <= top_next;
      m_tvalid <= m_tvalid_next;
    end
  end

  always_ff @(posedge clk) begin
    p       <= p_next;
    ptr     <= ptr_next;
    d       <= d_next;
    cnt     <= cnt_next;
    nb      <= nb_next;
    acc     <= acc_next;
    b       <= b_next;
    div_q   <= div_q_next;
    div_r   <= div_r_next;
    div_cnt <= div_cnt_next;
    neg_q   <= neg_q_next;
    neg_r   <= neg_r_next;
    op      <= op_next;
    rd_q    <= rd_next;
    m_tdata <= m_tdata_next;
  end

  always_comb begin
    state_next = state;
    clr_next = clr;
    pc_next = pc;
    depth_next = depth;
    run_next = run;
    fault_next = fault;
    top_next = top;
    p_next = p;
    ptr_next = ptr;
    d_next = d;
    cnt_next = cnt;
    nb_next = nb;
    acc_next = acc;
    b_next = b;
    div_q_next = div_q;
    div_r_next = div_r;
    div_cnt_next = div_cnt;
    neg_q_next = neg_q;
    neg_r_next = neg_r;
    op_next = op;
    rd_next = rd_q;
    m_tdata_next = m_tdata;
    m_tvalid_next = m_tvalid && !m_tready;
    mem_we = 1'b0;
    mem_waddr = ptr[AW-1:0];
    mem_wdata = '0;
    mem_raddr = ptr[AW-1:0];
    stk_we = 1'b0;
    stk_waddr = d[SW-1:0];
    stk_wdata = acc;
    stk_raddr = '0;

    case (state)
      S_CLEAR: begin
        mem_we = 1'b1;
        mem_waddr = clr[AW-1:0];
        clr_next = clr + (AW+1)'(1);
        if (clr == (AW+1)'(MEM_BYTES - 1)) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (s_tvalid) begin
          rd_next = '0;
          case (in_mode)
            MODE_WRITE: begin
              mem_we = 1'b1;
              mem_waddr = in_addr;
              mem_wdata = in_wdata;
              state_next = S_DONE;
            end
            MODE_READ: begin
              mem_raddr = in_addr;
              state_next = S_RDWAIT;
            end
            MODE_RESTART: begin
              pc_next = '0;
              depth_next = '0;
              run_next = RUN_OK;
              fault_next = ERR_NONE;
              top_next = '0;
              state_next = S_DONE;
            end
            default: begin
              if (run != RUN_OK) begin
                state_next = S_DONE;
              end else if (pc >= PW'(MEM_BYTES)) begin
                run_next = RUN_ERROR;
                fault_next = ERR_BOUNDS;
                state_next = S_DONE;
              end else begin
                mem_raddr = pc[AW-1:0];
                p_next = pc + PW'(1);
                state_next = S_FETCH;
              end
            end
          endcase
        end
      end
      S_RDWAIT: begin
        rd_next = mem_rdata;
        state_next = S_DONE;
      end
      S_FETCH: begin
        op_next = mem_rdata;
        nb_next = n_fetch;
        cnt_next = '0;
        acc_next = '0;
        case (mem_rdata)
          OP_HALT: begin
            run_next = RUN_HALTED;
            pc_next = p;
            state_next = S_DONE;
          end
          OP_PUSH0: begin
            d_next = depth;
            state_next = S_PUSH;
          end
          OP_PUSH8, OP_PUSH16, OP_PUSH32: begin
            if (!fits_p) begin
              run_next = RUN_ERROR;
              fault_next = ERR_BOUNDS;
              state_next = S_DONE;
            end else begin
              mem_raddr = p[AW-1:0];
              ptr_next = p + PW'(1);
              d_next = depth;
              state_next = S_IMM;
            end
          end
          OP_DROP: begin
            if (depth == '0) begin
              run_next = RUN_ERROR;
              fault_next = ERR_UNDER;
              state_next = S_DONE;
            end else begin
              stk_raddr = SW'(depth - DW'(2));
              d_next = depth - DW'(1);
              state_next = S_TOPRD;
            end
          end
          OP_DUP: begin
            if (depth == '0) begin
              run_next = RUN_ERROR;
              fault_next = ERR_UNDER;
              state_next = S_DONE;
            end else begin
              acc_next = top;
              d_next = depth;
              state_next = S_PUSH;
            end
          end
          OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_MOD, OP_EQ, OP_NEQ,
          OP_STORE8, OP_STORE16, OP_STORE32: begin
            if (depth < DW'(2)) begin
              run_next = RUN_ERROR;
              fault_next = ERR_UNDER;
              state_next = S_DONE;
            end else begin
              stk_raddr = SW'(depth - DW'(2));
              d_next = depth - DW'(2);
              state_next = S_BREAD;
            end
          end
          OP_LOAD8, OP_LOAD16, OP_LOAD32: begin
            if (depth == '0) begin
              run_next = RUN_ERROR;
              fault_next = ERR_UNDER;
              state_next = S_DONE;
            end else if (!fits_top) begin
              run_next = RUN_ERROR;
              fault_next = ERR_BOUNDS;
              state_next = S_DONE;
            end else begin
              mem_raddr = top[AW-1:0];
              ptr_next = top[PW-1:0] + PW'(1);
              d_next = depth - DW'(1);
              state_next = S_IMM;
            end
          end
          default: begin
            pc_next = p;
            state_next = S_DONE;
          end
        endcase
      end
      S_IMM: begin
        // gather bytes little-endian, one per cycle
        acc_next = acc | ({24'd0, mem_rdata} << {cnt, 3'b000});
        if (cnt == nb) begin
          if (op == OP_PUSH8 || op == OP_PUSH16 || op == OP_PUSH32) begin
            p_next = ptr;
          end
          state_next = S_PUSH;
        end else begin
          mem_raddr = ptr[AW-1:0];
          ptr_next = ptr + PW'(1);
          cnt_next = cnt + 2'd1;
        end
      end
      S_BREAD: begin
        b_next = stk_rdata;
        state_next = S_PUSH;
        case (op)
          OP_ADD: acc_next = sum;
          OP_SUB: acc_next = diff;
          OP_MUL: acc_next = prod;
          OP_EQ:  acc_next = {31'd0, top == stk_rdata};
          OP_NEQ: acc_next = {31'd0, top != stk_rdata};
          OP_DIV, OP_MOD: begin
            if (stk_rdata == '0) begin
              run_next = RUN_ERROR;
              fault_next = ERR_DIVZ;
              state_next = S_DONE;
            end else begin
              div_q_next = top[31] ? -top : top;
              b_next = stk_rdata[31] ? -stk_rdata : stk_rdata;
              div_r_next = '0;
              div_cnt_next = '0;
              neg_q_next = top[31] ^ stk_rdata[31];
              neg_r_next = top[31];
              state_next = S_DIV;
            end
          end
          OP_STORE8, OP_STORE16, OP_STORE32: begin
            if (!fits_top) begin
              run_next = RUN_ERROR;
              fault_next = ERR_BOUNDS;
              state_next = S_DONE;
            end else begin
              ptr_next = top[PW-1:0];
              cnt_next = '0;
              state_next = S_MEMWR;
            end
          end
          default: state_next = S_DONE;
        endcase
      end
      S_DIV: begin
        // restoring divide, one quotient bit a cycle
        if (!trial[32]) begin
          div_r_next = trial[31:0];
          div_q_next = {div_q[30:0], 1'b1};
        end else begin
          div_r_next = {div_r[30:0], div_q[31]};
          div_q_next = {div_q[30:0], 1'b0};
        end
        div_cnt_next = div_cnt + 5'd1;
        if (div_cnt == 5'd31) begin
          state_next = S_DIVEND;
        end
      end
      S_DIVEND: begin
        if (op == OP_DIV) begin
          acc_next = neg_q ? -div_q : div_q;
        end else begin
          acc_next = neg_r ? -div_r : div_r;
        end
        state_next = S_PUSH;
      end
      S_MEMWR: begin
        mem_we = 1'b1;
        mem_wdata = 8'(b >> {cnt, 3'b000});
        if (cnt == nb) begin
          stk_raddr = SW'(d - DW'(1));
          state_next = S_TOPRD;
        end else begin
          ptr_next = ptr + PW'(1);
          cnt_next = cnt + 2'd1;
        end
      end
      S_TOPRD: begin
        top_next = (d == '0) ? '0 : stk_rdata;
        depth_next = d;
        pc_next = p;
        state_next = S_DONE;
      end
      S_PUSH: begin
        if (d >= DW'(STACK_WORDS)) begin
          run_next = RUN_ERROR;
          fault_next = ERR_OVER;
        end else begin
          stk_we = 1'b1;
          top_next = acc;
          depth_next = d + DW'(1);
          pc_next = p;
        end
        state_next = S_DONE;
      end
      S_DONE: begin
        if (!m_tvalid || m_tready) begin
          m_tvalid_next = 1'b1;
          m_tdata_next = {7'd0, depth, top, pc, fault, run, rd_q};
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule
`default_nettype wire

// ===== hdl/sbm_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none
`include "stack_bytecode_machine_unit_assert.svh"
module sbm_checker (
  input wire logic                      clk,
  input wire logic                      rst,
  input wire logic                      s_tvalid,
  input wire logic                      s_tready,
  input wire logic [sbm_pkg::IN_W-1:0]  s_tdata,
  input wire logic                      m_tvalid,
  input wire logic                      m_tready,
  input wire logic [sbm_pkg::OUT_W-1:0] m_tdata
);
  import sbm_pkg::*;

  logic out_beat;
  assign out_beat = m_tvalid && m_tready;

  `SBM_ASSERT_NEXT(a_hold_valid, clk, rst, m_tvalid && !m_tready, m_tvalid, "valid dropped")
  `SBM_ASSERT_NEXT(a_hold_data, clk, rst, m_tvalid && !m_tready, $stable(m_tdata), "data moved")
  `SBM_ASSERT_NOW(a_err_code, clk, rst, out_beat && m_tdata[9:8] == RUN_ERROR,
                  m_tdata[12:10] != ERR_NONE, "error state without code")
  `SBM_ASSERT_NOW(a_depth, clk, rst, out_beat, m_tdata[64:58] <= DW'(STACK_WORDS),
                  "depth past stack size")
  `SBM_ASSERT_NOW(a_empty_top, clk, rst, out_beat && m_tdata[64:58] == '0,
                  m_tdata[57:26] == '0, "empty stack with nonzero top")

endmodule

bind stack_bytecode_machine_unit sbm_checker u_sbm_checker (.*);
`default_nettype wire
